// ----- src/vsd_pkg.sv -----
// Package for the video stream deframer: event kinds, parser phases, queue sizing
// and the structs passed between the parser, the event queue and the emitter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vsd_pkg;

    localparam int NAME_HEADER_BYTES = 64;
    localparam int Q_DEPTH           = 4;
    localparam int Q_AW              = $clog2(Q_DEPTH);

    localparam logic [31:0] NAME_HDR_LEN      = 32'(NAME_HEADER_BYTES);
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd16777216;

    localparam logic [31:0] ID_H264 = 32'h68323634;
    localparam logic [31:0] ID_H265 = 32'h68323635;
    localparam logic [31:0] ID_AV01 = 32'h61763031;

    localparam logic [1:0] CODEC_H264 = 2'd0;
    localparam logic [1:0] CODEC_H265 = 2'd1;
    localparam logic [1:0] CODEC_AV1  = 2'd2;

    localparam logic [31:0] WORD_LAST_IDX  = 32'd3;
    localparam logic [31:0] TS_BYTES       = 32'd8;
    localparam logic [31:0] FHDR_LAST_IDX  = 32'd11;

    typedef enum logic [1:0] {
        EV_STREAM = 2'd0,
        EV_FRAME  = 2'd1,
        EV_DATA   = 2'd2,
        EV_ERROR  = 2'd3
    } t_kind;

    typedef enum logic [6:0] {
        PH_NAME    = 7'b0000001,
        PH_CODEC   = 7'b0000010,
        PH_WIDTH   = 7'b0000100,
        PH_HEIGHT  = 7'b0001000,
        PH_FHDR    = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_HALT    = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        last;
        logic [1:0]  codec;
        logic        unknown;
        logic [63:0] word64;
        logic [31:0] word32;
    } t_evt;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        last;
        logic        cfg_frame;
        logic [61:0] timestamp;
        logic [31:0] size;
        logic [1:0]  codec;
        logic        unknown;
        logic [31:0] width;
        logic [31:0] height;
    } t_out;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

// ----- src/video_stream_deframer_top.sv -----
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------
// input    | push / full            | i_stream_byte
// results  | empty / pop            | o_event_kind .. o_frame_height
// config   | i_cfg_we               | i_cfg_wdata (max_payload_bytes)
//
// One byte is accepted per cycle while full is low; the parser updates one counter
// and one shift register per byte. A result is loaded into the output register at
// the earliest on the edge after the one that accepts its byte, through a four-entry
// event queue. full follows the queue alone, so a stalled result side throttles
// input only once the queue is full.
// Reset is synchronous and needs no clearing pass.
// Top level: instantiates vsd_parser, vsd_queue and vsd_emit; uses vsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module video_stream_deframer_top
    import vsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_stream_byte,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_event_kind,
    output logic [7:0]       o_data_byte,
    output logic             o_last_byte,
    output logic             o_cfg_frame,
    output logic [61:0]      o_timestamp_us,
    output logic [31:0]      o_frame_size,
    output logic [1:0]       o_codec,
    output logic             o_codec_unknown,
    output logic [31:0]      o_frame_width,
    output logic [31:0]      o_frame_height
);

    logic   w_accept;
    logic   w_q_push;
    logic   w_q_pop;
    logic   w_valid;
    t_evt   w_ev_in;
    t_evt   w_ev_out;
    t_qstat w_qstat;
    t_out   w_res;

    assign full     = w_qstat.full;
    assign w_accept = push && !w_qstat.full;

    vsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_stream_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ev_valid  (w_q_push),
        .o_ev        (w_ev_in)
    );

    vsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_evt   (w_ev_in),
        .i_pop   (w_q_pop),
        .o_evt   (w_ev_out),
        .o_stat  (w_qstat)
    );

    vsd_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (w_ev_out),
        .i_qstat (w_qstat),
        .i_pop   (pop),
        .o_q_pop (w_q_pop),
        .o_valid (w_valid),
        .o_res   (w_res)
    );

    assign empty           = !w_valid;
    assign o_event_kind    = w_res.kind;
    assign o_data_byte     = w_res.data;
    assign o_last_byte     = w_res.last;
    assign o_cfg_frame     = w_res.cfg_frame;
    assign o_timestamp_us  = w_res.timestamp;
    assign o_frame_size    = w_res.size;
    assign o_codec         = w_res.codec;
    assign o_codec_unknown = w_res.unknown;
    assign o_frame_width   = w_res.width;
    assign o_frame_height  = w_res.height;

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.full |-> !w_q_push)
        else $error("event queue written while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_qstat.empty)
        else $error("event queue read while empty");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> (empty || pop))
        else $error("output register overwritten before its request was taken");

    a_data_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |=> !empty)
        else $error("loaded request not presented");
`endif

endmodule

`default_nettype wire

// ----- src/vsd_parser.sv -----
// Front part of the deframer: accepts stream bytes, tracks the parse phase and
// builds one classified event per byte that causes a result. Uses vsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vsd_parser
    import vsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    output logic             o_ev_valid,
    output t_evt             o_ev
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt;
    logic [63:0] r_hdr, n_hdr;
    logic [31:0] r_size, n_size;
    logic [31:0] r_codec, n_codec;
    logic [31:0] r_width, n_width;
    logic [31:0] r_max;

    logic [31:0] sh32;
    logic [63:0] sh64;
    logic        pay_last;

    assign sh32     = {r_size[23:0], i_byte};
    assign sh64     = {r_hdr[55:0], i_byte};
    assign pay_last = ({1'b0, r_cnt} + 33'd1) >= {1'b0, r_size};

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_hdr      = r_hdr;
        n_size     = r_size;
        n_codec    = r_codec;
        n_width    = r_width;
        o_ev_valid = 1'b0;
        o_ev       = '0;
        if (i_accept) begin
            unique case (r_phase) inside
                PH_NAME: begin
                    if (r_cnt + 32'd1 >= NAME_HDR_LEN) begin
                        n_phase = PH_CODEC;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 32'd1;
                    end
                end
                PH_CODEC, PH_WIDTH, PH_HEIGHT: begin
                    n_size = sh32;
                    if (r_cnt < WORD_LAST_IDX) begin
                        n_cnt = r_cnt + 32'd1;
                    end else begin
                        n_cnt = '0;
                        if (r_phase == PH_CODEC) begin
                            n_codec = sh32;
                            n_size  = '0;
                            n_phase = PH_WIDTH;
                        end else if (r_phase == PH_WIDTH) begin
                            n_width = sh32;
                            n_size  = '0;
                            n_phase = PH_HEIGHT;
                        end else begin
                            o_ev_valid    = 1'b1;
                            o_ev.kind     = EV_STREAM;
                            o_ev.word64   = {r_width, sh32};
                            if (r_codec == ID_H265) begin
                                o_ev.codec = CODEC_H265;
                            end else if (r_codec == ID_AV01) begin
                                o_ev.codec = CODEC_AV1;
                            end else begin
                                o_ev.codec   = CODEC_H264;
                                o_ev.unknown = (r_codec != ID_H264);
                            end
                            n_size  = '0;
                            n_hdr   = '0;
                            n_phase = PH_FHDR;
                        end
                    end
                end
                PH_FHDR: begin
                    if (r_cnt < TS_BYTES) begin
                        n_hdr = sh64;
                        n_cnt = r_cnt + 32'd1;
                    end else begin
                        n_size = sh32;
                        if (r_cnt < FHDR_LAST_IDX) begin
                            n_cnt = r_cnt + 32'd1;
                        end else begin
                            n_cnt       = '0;
                            o_ev_valid  = 1'b1;
                            o_ev.word32 = sh32;
                            if (sh32 == 32'd0 || sh32 > r_max) begin
                                o_ev.kind = EV_ERROR;
                                n_phase   = PH_HALT;
                            end else begin
                                o_ev.kind   = EV_FRAME;
                                o_ev.word64 = r_hdr;
                                n_phase     = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    o_ev_valid = 1'b1;
                    o_ev.kind  = EV_DATA;
                    o_ev.data  = i_byte;
                    o_ev.last  = pay_last;
                    if (pay_last) begin
                        n_cnt   = '0;
                        n_size  = '0;
                        n_hdr   = '0;
                        n_phase = PH_FHDR;
                    end else begin
                        n_cnt = r_cnt + 32'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NAME;
            r_cnt   <= '0;
            r_hdr   <= '0;
            r_size  <= '0;
            r_codec <= '0;
            r_width <= '0;
            r_max   <= MAX_PAYLOAD_RESET;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_hdr   <= n_hdr;
            r_size  <= n_size;
            r_codec <= n_codec;
            r_width <= n_width;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/vsd_queue.sv -----
// Short event queue between the parser and the emitter, built from flip-flops.
// Uses vsd_pkg for the event type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module vsd_queue
    import vsd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_evt i_evt,
    input  wire logic i_pop,
    output t_evt      o_evt,
    output t_qstat    o_stat
);

    t_evt            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, r_rptr;
    logic [Q_AW:0]   r_count;

    assign o_stat.full  = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_evt        = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/vsd_emit.sv -----
// Back part of the deframer: takes events from the queue, formats the result
// fields and holds them in the output register until popped. Uses vsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vsd_emit
    import vsd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_evt   i_evt,
    input  wire t_qstat i_qstat,
    input  wire logic   i_pop,
    output logic        o_q_pop,
    output logic        o_valid,
    output t_out        o_res
);

    logic r_valid;
    t_out r_res, n_res;

    assign o_q_pop = !i_qstat.empty && (!r_valid || i_pop);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_res      = '0;
        n_res.kind = i_evt.kind;
        case (i_evt.kind)
            EV_STREAM: begin
                n_res.codec   = i_evt.codec;
                n_res.unknown = i_evt.unknown;
                n_res.width   = i_evt.word64[63:32];
                n_res.height  = i_evt.word64[31:0];
            end
            EV_FRAME: begin
                n_res.cfg_frame = i_evt.word64[63];
                n_res.timestamp = i_evt.word64[63] ? '0 : i_evt.word64[61:0];
                n_res.size      = i_evt.word32;
            end
            EV_DATA: begin
                n_res.data = i_evt.data;
                n_res.last = i_evt.last;
            end
            default: begin
                n_res.size = i_evt.word32;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire
